@@ rtl/a2b_pkg.sv @@
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and constants for the length-prefixed to Annex B converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

  // Input function codes.
  localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SPS = 2'd1;
  localparam logic [1:0] FUNC_LOAD_PPS = 2'd2;

  // Length size register codes; any other code selects four-byte lengths.
  localparam logic [1:0] LSC_ONE   = 2'd0;
  localparam logic [1:0] LSC_TWO   = 2'd1;
  localparam logic [1:0] LSC_FOUR  = 2'd2;

  // NAL unit type of an access unit delimiter.
  localparam logic [4:0] NAL_TYPE_AUD = 5'd9;

  // Fixed byte sequences.
  localparam int AUD_LEN    = 6;
  localparam int START3_LEN = 3;
  localparam int START4_LEN = 4;

  // Command queue depth between the front and back ends.
  localparam int QUEUE_DEPTH = 4;

  // Byte of the inserted access unit delimiter 00 00 00 01 09 F0.
  function automatic logic [7:0] aud_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd3:    b = 8'h01;
      3'd4:    b = 8'h09;
      3'd5:    b = 8'hf0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One input beat.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        first_flag;
    logic        sync_sample;
    logic [23:0] sample_length;
  } in_item_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Kind of work handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_EMIT,
    CMD_LOAD_SPS,
    CMD_LOAD_PPS
  } cmd_kind_e;

  // Queued command. For an emit, the flags select which pieces go out:
  // delimiter, parameter sets (right after the delimiter when aud is set,
  // otherwise at the end), start code, and the payload byte itself.
  typedef struct packed {
    cmd_kind_e  kind;
    logic       first;
    logic       aud;
    logic       pre;
    logic       st3;
    logic       byte_en;
    logic [7:0] data;
  } cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ rtl/a2b_front.sv @@
// ----------------------------------------------------------------------------
// a2b_front
// Parses sample bytes (length fields, payload, drops) and turns each beat
// into at most one command for the back end.
// ----------------------------------------------------------------------------
module a2b_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  a2b_pkg::in_item_t    in_data_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_data_i,
  output logic                 cmd_push_o,
  output a2b_pkg::cmd_t        cmd_o,
  input  a2b_pkg::fifo_stat_t  fifo_stat_i
);
  import a2b_pkg::*;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DROP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  lsc_q, lsc_d;
  logic [23:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [23:0] nalu_left_q, nalu_left_d;
  logic [23:0] sample_left_q, sample_left_d;
  logic        first_nalu_q, first_nalu_d;
  logic        prefix_q, prefix_d;
  logic        nal_start_q, nal_start_d;

  logic        accept;
  logic [2:0]  field_size;
  logic [23:0] sample_left_pre;
  logic        field_ok;

  // The queue is the only reason to hold off the source.
  assign in_stall_o  = fifo_stat_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !fifo_stat_i.full;

  // Size of a new length field.
  always_comb begin
    case (lsc_q)
      LSC_ONE: field_size = 3'd1;
      LSC_TWO: field_size = 3'd2;
      default: field_size = 3'd4;
    endcase
  end

  // Parser step for one accepted beat.
  always_comb begin
    phase_d         = phase_q;
    lsc_d           = lsc_q;
    acc_d           = acc_q;
    ovf_d           = ovf_q;
    len_left_d      = len_left_q;
    nalu_left_d     = nalu_left_q;
    sample_left_d   = sample_left_q;
    first_nalu_d    = first_nalu_q;
    prefix_d        = prefix_q;
    nal_start_d     = nal_start_q;
    cmd_push_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.kind      = CMD_EMIT;
    cmd_o.first     = in_data_i.first_flag;
    cmd_o.data      = in_data_i.data_byte;
    sample_left_pre = '0;
    field_ok        = 1'b1;

    if (cfg_valid_i) begin
      lsc_d = cfg_data_i;
    end

    if (accept) begin
      case (in_data_i.func)
        FUNC_LOAD_SPS: begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_LOAD_SPS;
        end
        FUNC_LOAD_PPS: begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_LOAD_PPS;
        end
        FUNC_SAMPLE: begin
          // A first byte restarts the parser for a new sample.
          if (in_data_i.first_flag) begin
            sample_left_d = in_data_i.sample_length;
            phase_d       = PH_LENGTH;
            len_left_d    = '0;
            nalu_left_d   = '0;
            first_nalu_d  = 1'b1;
            prefix_d      = in_data_i.sync_sample;
            nal_start_d   = 1'b0;
          end
          if (sample_left_d != '0) begin
            sample_left_pre = sample_left_d;
            sample_left_d   = sample_left_d - 24'd1;
            case (phase_d)
              PH_LENGTH: begin
                // Start a field, or drop if the sample is too short for it.
                if (len_left_d == '0) begin
                  if (sample_left_pre < 24'(field_size)) begin
                    phase_d  = PH_DROP;
                    field_ok = 1'b0;
                  end else begin
                    len_left_d = field_size;
                    acc_d      = '0;
                    ovf_d      = 1'b0;
                  end
                end
                if (field_ok) begin
                  ovf_d      = ovf_d | (acc_d[23:16] != 8'd0);
                  acc_d      = {acc_d[15:0], in_data_i.data_byte};
                  len_left_d = len_left_d - 3'd1;
                  if (len_left_d == '0) begin
                    if (ovf_d || (acc_d > sample_left_d)) begin
                      phase_d = PH_DROP;
                    end else if (acc_d != '0) begin
                      nalu_left_d = acc_d;
                      phase_d     = PH_PAYLOAD;
                      nal_start_d = 1'b1;
                    end else if (first_nalu_d) begin
                      // Empty first NAL: delimiter, sets, start code.
                      if (sample_left_d == '0) begin
                        phase_d = PH_DROP;
                      end else begin
                        first_nalu_d = 1'b0;
                        cmd_push_o   = 1'b1;
                        cmd_o.aud    = 1'b1;
                        cmd_o.pre    = prefix_d;
                        cmd_o.st3    = 1'b1;
                        prefix_d     = 1'b0;
                      end
                    end else begin
                      // Empty later NAL: start code, then pending sets.
                      cmd_push_o = 1'b1;
                      cmd_o.st3  = 1'b1;
                      cmd_o.pre  = prefix_d;
                      prefix_d   = 1'b0;
                    end
                  end
                end
              end
              PH_PAYLOAD: begin
                cmd_push_o    = 1'b1;
                cmd_o.byte_en = 1'b1;
                if (nal_start_d) begin
                  nal_start_d = 1'b0;
                  cmd_o.st3   = 1'b1;
                  // The header byte decides whether a delimiter is inserted.
                  if (first_nalu_d) begin
                    first_nalu_d = 1'b0;
                    if (in_data_i.data_byte[4:0] != NAL_TYPE_AUD) begin
                      cmd_o.aud = 1'b1;
                      cmd_o.pre = prefix_d;
                      prefix_d  = 1'b0;
                    end
                  end
                end
                nalu_left_d = nalu_left_d - 24'd1;
                if (nalu_left_d == '0) begin
                  phase_d = PH_LENGTH;
                  if (prefix_d) begin
                    cmd_o.pre = 1'b1;
                    prefix_d  = 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Parser state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_LENGTH;
      lsc_q         <= LSC_FOUR;
      acc_q         <= '0;
      ovf_q         <= 1'b0;
      len_left_q    <= '0;
      nalu_left_q   <= '0;
      sample_left_q <= '0;
      first_nalu_q  <= 1'b1;
      prefix_q      <= 1'b0;
      nal_start_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      lsc_q         <= lsc_d;
      acc_q         <= acc_d;
      ovf_q         <= ovf_d;
      len_left_q    <= len_left_d;
      nalu_left_q   <= nalu_left_d;
      sample_left_q <= sample_left_d;
      first_nalu_q  <= first_nalu_d;
      prefix_q      <= prefix_d;
      nal_start_q   <= nal_start_d;
    end
  end

endmodule

@@ rtl/a2b_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// a2b_cmd_fifo
// Short command queue that decouples the parser from the byte sequencer.
// ----------------------------------------------------------------------------
module a2b_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  a2b_pkg::cmd_t        data_i,
  input  logic                 pop_i,
  output a2b_pkg::cmd_t        data_o,
  output a2b_pkg::fifo_stat_t  stat_o
);
  import a2b_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/a2b_back.sv @@
// ----------------------------------------------------------------------------
// a2b_back
// Byte sequencer: executes queued commands, holds the parameter-set stores
// and drives the registered output beat.
// ----------------------------------------------------------------------------
module a2b_back #(
  parameter int SPS_BYTES = 24,
  parameter int PPS_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  a2b_pkg::cmd_t       cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output a2b_pkg::out_item_t  out_data_o
);
  import a2b_pkg::*;

  localparam int SpsAw  = (SPS_BYTES > 1) ? $clog2(SPS_BYTES) : 1;
  localparam int SpsCw  = $clog2(SPS_BYTES + 1);
  localparam int PpsAw  = (PPS_BYTES > 1) ? $clog2(PPS_BYTES) : 1;
  localparam int PpsCw  = $clog2(PPS_BYTES + 1);
  localparam int MaxPs  = (SPS_BYTES > PPS_BYTES) ? SPS_BYTES : PPS_BYTES;
  localparam int MaxSeg = (MaxPs > AUD_LEN) ? MaxPs : AUD_LEN;
  localparam int IdxW   = $clog2(MaxSeg);
  localparam int LenW   = $clog2(MaxSeg + 1);
  localparam int NumPos = 11;

  // Piece positions in output order.
  localparam logic [3:0] POS_AUD       = 4'd0;
  localparam logic [3:0] POS_E_HDR_SPS = 4'd1;
  localparam logic [3:0] POS_E_SPS     = 4'd2;
  localparam logic [3:0] POS_E_HDR_PPS = 4'd3;
  localparam logic [3:0] POS_E_PPS     = 4'd4;
  localparam logic [3:0] POS_ST3       = 4'd5;
  localparam logic [3:0] POS_BYTE      = 4'd6;
  localparam logic [3:0] POS_L_HDR_SPS = 4'd7;
  localparam logic [3:0] POS_L_SPS     = 4'd8;
  localparam logic [3:0] POS_L_HDR_PPS = 4'd9;
  localparam logic [3:0] POS_L_PPS     = 4'd10;

  // Which pieces a command sends.
  function automatic logic [NumPos-1:0] piece_mask(input cmd_t c, input logic sps_nz,
                                                   input logic pps_nz);
    logic [NumPos-1:0] m;
    logic early;
    logic late;
    early = c.pre && c.aud;
    late  = c.pre && !c.aud;
    m = '0;
    m[POS_AUD]       = c.aud;
    m[POS_E_HDR_SPS] = early;
    m[POS_E_SPS]     = early && sps_nz;
    m[POS_E_HDR_PPS] = early;
    m[POS_E_PPS]     = early && pps_nz;
    m[POS_ST3]       = c.st3;
    m[POS_BYTE]      = c.byte_en;
    m[POS_L_HDR_SPS] = late;
    m[POS_L_SPS]     = late && sps_nz;
    m[POS_L_HDR_PPS] = late;
    m[POS_L_PPS]     = late && pps_nz;
    return m;
  endfunction

  // Lowest enabled position at or after start, with a found flag on top.
  function automatic logic [4:0] next_piece(input logic [NumPos-1:0] m,
                                            input logic [3:0] start);
    logic [4:0] r;
    r = '0;
    for (int i = NumPos - 1; i >= 0; i--) begin
      if (m[i] && (4'(i) >= start)) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

  logic [7:0]       sps_mem_q [SPS_BYTES];
  logic [7:0]       pps_mem_q [PPS_BYTES];
  logic [SpsCw-1:0] sps_cnt_q;
  logic [PpsCw-1:0] pps_cnt_q;

  logic             busy_q;
  cmd_t             cmd_q;
  logic [3:0]       pos_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic              sps_nz, pps_nz;
  logic [NumPos-1:0] run_mask, head_mask;
  logic [4:0]        run_next, head_first;
  logic              emit_ok;
  logic [7:0]        piece_byte;
  logic [LenW-1:0]   piece_len;
  logic              piece_end;
  logic              sps_wr, pps_wr;
  logic [SpsAw-1:0]  sps_waddr;
  logic [PpsAw-1:0]  pps_waddr;

  assign sps_nz     = (sps_cnt_q != '0);
  assign pps_nz     = (pps_cnt_q != '0);
  assign run_mask   = piece_mask(cmd_q, sps_nz, pps_nz);
  assign head_mask  = piece_mask(cmd_i, sps_nz, pps_nz);
  assign run_next   = next_piece(run_mask, pos_q + 4'd1);
  assign head_first = next_piece(head_mask, POS_AUD);

  assign cmd_pop_o   = !busy_q && !cmd_empty_i;
  assign emit_ok     = busy_q && (!out_valid_q || !out_stall_i);
  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Byte and length of the current piece.
  always_comb begin
    case (pos_q)
      POS_AUD: begin
        piece_byte = aud_byte(idx_q[2:0]);
        piece_len  = LenW'(AUD_LEN);
      end
      POS_E_HDR_SPS, POS_E_HDR_PPS, POS_L_HDR_SPS, POS_L_HDR_PPS: begin
        piece_byte = (idx_q == IdxW'(START4_LEN - 1)) ? 8'h01 : 8'h00;
        piece_len  = LenW'(START4_LEN);
      end
      POS_E_SPS, POS_L_SPS: begin
        piece_byte = sps_mem_q[idx_q[SpsAw-1:0]];
        piece_len  = LenW'(sps_cnt_q);
      end
      POS_E_PPS, POS_L_PPS: begin
        piece_byte = pps_mem_q[idx_q[PpsAw-1:0]];
        piece_len  = LenW'(pps_cnt_q);
      end
      POS_ST3: begin
        piece_byte = (idx_q == IdxW'(START3_LEN - 1)) ? 8'h01 : 8'h00;
        piece_len  = LenW'(START3_LEN);
      end
      default: begin
        piece_byte = cmd_q.data;
        piece_len  = LenW'(1);
      end
    endcase
  end

  assign piece_end = ((LenW'(idx_q) + LenW'(1)) == piece_len);

  // Parameter-set store writes: a first byte restarts, extra bytes are ignored.
  assign sps_wr    = cmd_pop_o && (cmd_i.kind == CMD_LOAD_SPS) &&
                     (cmd_i.first || (sps_cnt_q < SpsCw'(SPS_BYTES)));
  assign pps_wr    = cmd_pop_o && (cmd_i.kind == CMD_LOAD_PPS) &&
                     (cmd_i.first || (pps_cnt_q < PpsCw'(PPS_BYTES)));
  assign sps_waddr = cmd_i.first ? '0 : sps_cnt_q[SpsAw-1:0];
  assign pps_waddr = cmd_i.first ? '0 : pps_cnt_q[PpsAw-1:0];

  // Sequencer, store counts and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cmd_q       <= '0;
      pos_q       <= POS_AUD;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      sps_cnt_q   <= '0;
      pps_cnt_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_ok) begin
        out_valid_q     <= 1'b1;
        out_q.out_byte  <= piece_byte;
        out_q.run_last  <= piece_end && !run_next[4];
        if (piece_end) begin
          idx_q <= '0;
          if (run_next[4]) begin
            pos_q <= run_next[3:0];
          end else begin
            busy_q <= 1'b0;
          end
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (cmd_pop_o) begin
        case (cmd_i.kind)
          CMD_EMIT: begin
            cmd_q  <= cmd_i;
            pos_q  <= head_first[3:0];
            idx_q  <= '0;
            busy_q <= 1'b1;
          end
          CMD_LOAD_SPS: begin
            if (sps_wr) begin
              sps_cnt_q <= SpsCw'(sps_waddr) + SpsCw'(1);
            end
          end
          CMD_LOAD_PPS: begin
            if (pps_wr) begin
              pps_cnt_q <= PpsCw'(pps_waddr) + PpsCw'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Parameter-set stores.
  always_ff @(posedge clk_i) begin
    if (sps_wr) begin
      sps_mem_q[sps_waddr] <= cmd_i.data;
    end
    if (pps_wr) begin
      pps_mem_q[pps_waddr] <= cmd_i.data;
    end
  end

endmodule

@@ rtl/avcc_to_annexb_converter_unit.sv @@
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_unit
// H.264 length-prefixed sample to Annex B byte-stream converter, one byte
// per input beat, with delimiter and parameter-set insertion.
// ----------------------------------------------------------------------------
// The front end takes one input beat per cycle whenever its four-entry
// command queue has room; beats with no back-end work (length bytes, dropped
// bytes, ignored codes) push no command. The back-end sequencer fetches a
// queued command only while idle and then sends its output bytes one per
// cycle while the output is not stalled, so each command, a plain payload
// byte as much as an insertion burst, is done before the next is fetched;
// a parameter-set load byte only writes its store. Output bytes leave from a
// register, so the input side keeps running while the output is stalled
// until the queue fills. Parameter-set loads pass through the same queue,
// so they take effect in order with the bursts that read the stores.
module avcc_to_annexb_converter_unit #(
  parameter int SPS_BYTES = 24,
  parameter int PPS_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  a2b_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output a2b_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);
  import a2b_pkg::*;

  logic       cmd_push;
  logic       cmd_pop;
  cmd_t       cmd_in;
  cmd_t       cmd_head;
  fifo_stat_t fifo_stat;
  logic       back_busy;

  // Parser.
  a2b_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .fifo_stat_i (fifo_stat)
  );

  // Command queue.
  a2b_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .stat_o (fifo_stat)
  );

  // Byte sequencer.
  a2b_back #(
    .SPS_BYTES (SPS_BYTES),
    .PPS_BYTES (PPS_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (fifo_stat.empty),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // The parser never pushes into a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !fifo_stat.full)
    else $error("command pushed into a full queue");

  // The sequencer only fetches when a command is waiting.
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !fifo_stat.empty)
    else $error("command fetched from an empty queue");

  // A new output beat only appears while a command is being executed.
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_busy))
    else $error("output beat without an active command");
`endif

endmodule

@@ sim/a2b_stream_checker.sv @@
// ----------------------------------------------------------------------------
// a2b_stream_checker
// Watches the input, output and register channels of the Annex B converter,
// works out the output bytes each accepted input beat must cause, and
// compares every accepted output beat with the oldest byte still owed.
// ----------------------------------------------------------------------------
module a2b_stream_checker #(
  parameter int SPS_BYTES = 24,
  parameter int PPS_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  a2b_pkg::in_item_t   in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  a2b_pkg::out_item_t  out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  import a2b_pkg::*;

  typedef enum logic [1:0] {
    PARSE_LEN,
    PARSE_BODY,
    PARSE_SKIP
  } parse_phase_e;

  localparam logic [7:0] AUD_SEQ [AUD_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'hf0};

  // Shadow copy of the converter state.
  logic [1:0]   len_code;
  logic [7:0]   sps_mem [SPS_BYTES];
  logic [7:0]   pps_mem [PPS_BYTES];
  int unsigned  sps_cnt;
  int unsigned  pps_cnt;
  parse_phase_e parse_ph;
  logic [31:0]  len_acc;
  int unsigned  len_bytes_left;
  logic [31:0]  nal_left;
  logic [23:0]  sample_left;
  logic         first_nal;
  logic         sets_pending;

  // Bytes of the current beat, and all bytes still owed by the converter.
  out_item_t burst_q [$];
  out_item_t annexb_owed_q [$];
  out_item_t want;
  int        fails;

  function automatic int unsigned length_field_bytes(input logic [1:0] code);
    case (code)
      LSC_ONE: return 1;
      LSC_TWO: return 2;
      default: return 4;
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    out_item_t ob;
    ob.out_byte = b;
    ob.run_last = 1'b0;
    burst_q = {burst_q, ob};
  endtask

  // Start code of n bytes: zeros followed by a single one.
  task automatic put_start_code(input int n);
    for (int i = 0; i < n - 1; i++) put_byte(8'h00);
    put_byte(8'h01);
  endtask

  task automatic put_delimiter();
    for (int i = 0; i < AUD_LEN; i++) put_byte(AUD_SEQ[i]);
  endtask

  // Stored SPS and PPS go out once per sync sample.
  task automatic put_param_sets();
    if (!sets_pending) return;
    sets_pending = 1'b0;
    put_start_code(START4_LEN);
    for (int i = 0; i < sps_cnt; i++) put_byte(sps_mem[i]);
    put_start_code(START4_LEN);
    for (int i = 0; i < pps_cnt; i++) put_byte(pps_mem[i]);
  endtask

  // One sample byte through the length / payload parser.
  task automatic parse_sample_byte(input in_item_t it);
    logic [23:0] left_before;
    int unsigned field_bytes;
    if (it.first_flag) begin
      sample_left    = it.sample_length;
      parse_ph       = PARSE_LEN;
      len_acc        = '0;
      len_bytes_left = 0;
      nal_left       = '0;
      first_nal      = 1'b1;
      sets_pending   = it.sync_sample;
    end
    if (sample_left == 0) return;
    left_before = sample_left;
    sample_left = sample_left - 24'd1;
    if (parse_ph == PARSE_SKIP) return;

    if (parse_ph == PARSE_LEN) begin
      // A length field that the sample cannot hold drops the rest.
      if (len_bytes_left == 0) begin
        field_bytes = length_field_bytes(len_code);
        if (left_before < field_bytes) begin
          parse_ph = PARSE_SKIP;
          return;
        end
        len_bytes_left = field_bytes;
        len_acc        = '0;
      end
      len_acc        = {len_acc[23:0], it.data_byte};
      len_bytes_left = len_bytes_left - 1;
      if (len_bytes_left != 0) return;
      if (len_acc > {8'd0, sample_left}) begin
        parse_ph = PARSE_SKIP;
        return;
      end
      if (len_acc != 0) begin
        nal_left = len_acc;
        parse_ph = PARSE_BODY;
        return;
      end
      // Zero-length NAL: start code plus any delimiter and pending sets.
      if (first_nal) begin
        if (sample_left == 0) begin
          parse_ph = PARSE_SKIP;
          return;
        end
        first_nal = 1'b0;
        put_delimiter();
        put_param_sets();
        put_start_code(START3_LEN);
      end else begin
        put_start_code(START3_LEN);
        put_param_sets();
      end
    end else begin
      // The header byte decides whether a delimiter must be inserted.
      if (nal_left == len_acc) begin
        if (first_nal) begin
          first_nal = 1'b0;
          if (it.data_byte[4:0] != NAL_TYPE_AUD) begin
            put_delimiter();
            put_param_sets();
          end
        end
        put_start_code(START3_LEN);
      end
      put_byte(it.data_byte);
      nal_left = nal_left - 1;
      if (nal_left == 0) begin
        parse_ph = PARSE_LEN;
        put_param_sets();
      end
    end
  endtask

  // Works out the output bytes of one accepted input beat.
  task automatic predict_annexb(input in_item_t it);
    burst_q.delete();
    case (it.func)
      FUNC_LOAD_SPS: begin
        if (it.first_flag) sps_cnt = 0;
        if (sps_cnt < SPS_BYTES) begin
          sps_mem[sps_cnt] = it.data_byte;
          sps_cnt++;
        end
      end
      FUNC_LOAD_PPS: begin
        if (it.first_flag) pps_cnt = 0;
        if (pps_cnt < PPS_BYTES) begin
          pps_mem[pps_cnt] = it.data_byte;
          pps_cnt++;
        end
      end
      FUNC_SAMPLE: parse_sample_byte(it);
      default: ;
    endcase
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].run_last = 1'b1;
      annexb_owed_q = {annexb_owed_q, burst_q};
    end
  endtask

  // Channel monitor: register writes, input beats, then output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_code       = LSC_FOUR;
      sps_cnt        = 0;
      pps_cnt        = 0;
      parse_ph       = PARSE_LEN;
      len_acc        = '0;
      len_bytes_left = 0;
      nal_left       = '0;
      sample_left    = '0;
      first_nal      = 1'b1;
      sets_pending   = 1'b0;
      fails          = 0;
      annexb_owed_q.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) len_code = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_annexb(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (annexb_owed_q.size() == 0) begin
          $display("%0t: output beat with nothing owed: expected none, actual byte %02h last %0b",
                   $time, out_data_i.out_byte, out_data_i.run_last);
          fails++;
        end else begin
          want = annexb_owed_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.out_byte, out_data_i.out_byte);
            fails++;
          end
          if (out_data_i.run_last !== want.run_last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, want.run_last, out_data_i.run_last);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= annexb_owed_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the length-prefixed to Annex B converter. Runs a
// short directed sequence, then random samples, parameter-set loads and
// noise under every length size setting, with random idling on both sides
// and one long output hold-off. A checker beside the block does the checks.
// ----------------------------------------------------------------------------
module tb_top;

  import a2b_pkg::*;

  localparam int SPS_BYTES = 24;
  localparam int PPS_BYTES = 16;

  // Unused function code, and the unused length size code (four bytes).
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] LSC_SPARE   = 2'd3;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 150;
  localparam int PHASE_ITEMS   = 30;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  int         fail_cnt;
  int         pending_cnt;
  int         cycle_cnt = 0;
  int         items_sent = 0;
  int         rx_count = 0;
  bit         calm_tx = 1'b0;
  bit         calm_rx = 1'b0;
  logic [7:0] body_q [$];

  avcc_to_annexb_converter_unit #(
    .SPS_BYTES(SPS_BYTES),
    .PPS_BYTES(PPS_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  a2b_stream_checker #(
    .SPS_BYTES(SPS_BYTES),
    .PPS_BYTES(PPS_BYTES)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_cnt),
    .pending_o   (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one beat after a random gap and waits until it is taken.
  task automatic send_beat(input in_item_t it);
    int gap;
    if ($urandom_range(0, 19) == 0) calm_tx = !calm_tx;
    gap = calm_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
  endtask

  // A beat that does real work; fields read only on a first byte are random
  // elsewhere.
  task automatic send_byte(input logic [1:0] func, input logic [7:0] b, input bit first,
                           input bit sync, input logic [23:0] slen);
    in_item_t it;
    it.func          = func;
    it.data_byte     = b;
    it.first_flag    = first;
    it.sync_sample   = sync;
    it.sample_length = slen;
    send_beat(it);
    items_sent++;
  endtask

  task automatic send_sample(input bit sync, input logic [23:0] slen);
    foreach (body_q[i]) begin
      if (i == 0) send_byte(FUNC_SAMPLE, body_q[i], 1'b1, sync, slen);
      else send_byte(FUNC_SAMPLE, body_q[i], 1'b0, 1'($urandom), 24'($urandom));
    end
  endtask

  task automatic send_loads(input logic [1:0] func, input bit restart);
    foreach (body_q[i]) begin
      send_byte(func, body_q[i], restart && (i == 0), 1'($urandom), 24'($urandom));
    end
  endtask

  // Registers are written only once every owed byte is out and the block
  // has had time to finish beats that cause no output.
  task automatic write_length_size(input logic [1:0] code);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed sample with random content; about one in five is broken by
  // a wrong sample length or an oversized NAL length.
  task automatic random_sample(input logic [1:0] code);
    int          field_bytes;
    int          nal_cnt;
    int          nal_len;
    int          pick;
    logic [31:0] len_word;
    logic [2:0]  nri;
    logic [7:0]  hdr;
    logic [23:0] slen;
    case (code)
      LSC_ONE: field_bytes = 1;
      LSC_TWO: field_bytes = 2;
      default: field_bytes = 4;
    endcase
    body_q.delete();
    nal_cnt = $urandom_range(1, 3);
    for (int n = 0; n < nal_cnt; n++) begin
      nal_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
      len_word = nal_len;
      if ($urandom_range(0, 19) == 0) len_word = $urandom;
      for (int k = field_bytes - 1; k >= 0; k--) body_q = {body_q, len_word[8*k +: 8]};
      for (int j = 0; j < nal_len; j++) begin
        if (j == 0 && $urandom_range(0, 3) == 0) begin
          nri    = 3'($urandom);
          hdr    = {nri, NAL_TYPE_AUD};
          body_q = {body_q, hdr};
        end else begin
          body_q = {body_q, 8'($urandom)};
        end
      end
    end
    slen = 24'(body_q.size());
    pick = $urandom_range(0, 9);
    if (pick == 0) slen = 24'($urandom_range(0, body_q.size()));
    else if (pick == 1) slen = 24'(body_q.size() + $urandom_range(1, 8));
    send_sample($urandom_range(0, 4) < 2, slen);
  endtask

  task automatic random_loads(input logic [1:0] func);
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 5);
    body_q.delete();
    for (int i = 0; i < n; i++) body_q = {body_q, 8'($urandom)};
    send_loads(func, $urandom_range(0, 4) != 0);
  endtask

  // Beats that start no new sample: the unused code, which the block ignores, or a stray sample byte.
  task automatic send_noise();
    in_item_t it;
    it.func          = $urandom_range(0, 1) ? FUNC_UNUSED : FUNC_SAMPLE;
    it.data_byte     = 8'($urandom);
    it.first_flag    = (it.func == FUNC_UNUSED) ? 1'($urandom) : 1'b0;
    it.sync_sample   = 1'($urandom);
    it.sample_length = 24'($urandom);
    send_beat(it);
  endtask

  task automatic random_item(input logic [1:0] code);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) send_noise();
    else if (pick < 14) random_loads(FUNC_LOAD_SPS);
    else if (pick < 20) random_loads(FUNC_LOAD_PPS);
    else random_sample(code);
  endtask

  // Output side: random stalls per beat, calm stretches, one long hold-off.
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) calm_rx = !calm_rx;
      n = calm_rx ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      rx_count++;
      if (rx_count == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  // Input side and verdict.
  initial begin : tx_side
    int          drain;
    int          phase_idx;
    int          phase_start;
    logic [1:0]  code;
    in_item_t    it;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = LSC_FOUR;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with one-byte length fields.
    write_length_size(LSC_ONE);
    it = '{func: FUNC_UNUSED, data_byte: 8'hff, first_flag: 1'b1, sync_sample: 1'b1,
           sample_length: 24'hffffff};
    send_beat(it);
    it = '{func: FUNC_SAMPLE, data_byte: 8'h00, first_flag: 1'b0, sync_sample: 1'b0,
           sample_length: 24'h000000};
    send_beat(it);
    // Sync sample led by its own delimiter while both stores are empty.
    body_q = {8'h01, 8'h29, 8'h00};
    send_sample(1'b1, 24'd3);
    body_q = {8'h67, 8'h42, 8'hff};
    send_loads(FUNC_LOAD_SPS, 1'b1);
    body_q = {8'h68, 8'hce};
    send_loads(FUNC_LOAD_PPS, 1'b1);
    // Inserted delimiter followed by the parameter sets.
    body_q = {8'h01, 8'h65};
    send_sample(1'b1, 24'd2);
    // Zero-length first NAL, then one that ends the sample alone.
    body_q = {8'h00, 8'h01, 8'h41};
    send_sample(1'b1, 24'd3);
    body_q = {8'h00};
    send_sample(1'b1, 24'd1);
    // Length past the sample end, abandoned by the next sample.
    body_q = {8'h05, 8'haa};
    send_sample(1'b0, 24'd3);
    body_q = {8'hff};
    send_sample(1'b0, 24'hffffff);
    body_q = {8'h01, 8'h00};
    send_sample(1'b0, 24'd2);
    body_q = {8'h01, 8'hff};
    send_sample(1'b1, 24'd2);

    // Random part, one register setting per phase.
    items_sent = 0;
    phase_idx  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase_idx)
        0:       code = LSC_FOUR;
        1:       code = LSC_SPARE;
        2:       code = LSC_TWO;
        3:       code = LSC_ONE;
        default: code = 2'($urandom);
      endcase
      write_length_size(code);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
        random_item(code);
      end
      phase_idx++;
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle.
    @(posedge clk_i);
    drain = 0;
    while (pending_cnt != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
